FILE: hdl/three_wire_thermometer_master_defines.svh
// Assertion helpers for the three-wire thermometer master
`ifndef THREE_WIRE_THERMOMETER_MASTER_DEFINES_SVH
`define THREE_WIRE_THERMOMETER_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
`define TWTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TWTM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/twtm_pkg.sv
package twtm_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int READ_BITS = 9;
    localparam int TEMP_W    = 9;

    typedef struct packed {
        logic       action;
        logic [2:0] device_id;
        logic [7:0] command_byte;
        logic [7:0] data_byte;
        logic       send_data;
        logic       read_result;
        logic       dq_in;
    } t_in_item;

    typedef struct packed {
        logic              clock_out;
        logic              dq_out;
        logic              dq_drive;
        logic [2:0]        select_out;
        logic              busy_res;
        logic              done_res;
        logic [TEMP_W-1:0] temperature;
    } t_out_item;

endpackage

FILE: hdl/twtm_stream_if.sv
interface twtm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/three_wire_thermometer_master.sv
// Each result is registered in the result register, or the skid register on a stall.
// Throughput: one item per cycle while the skid register is empty; the phase step is a
// single pass between the state and result registers, with a two-deep output buffer.
// Reset (synchronous, active low): phase idle, counters and shift registers cleared,
// timing registers back to 10/10/30/5/10/1000/30000, output buffer empty.
`include "three_wire_thermometer_master_defines.svh"

module three_wire_thermometer_master (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [twtm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [twtm_pkg::CFG_W-1:0]         i_cfg_data,
    twtm_stream_if.sink                        i_item,
    twtm_stream_if.source                      o_res
);
    import twtm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SETTLE  = 4'd1,
        PH_WLOW    = 4'd2,
        PH_WHIGH   = 4'd3,
        PH_TAIL    = 4'd4,
        PH_RELEASE = 4'd5,
        PH_RLOW    = 4'd6,
        PH_RWAIT   = 4'd7,
        PH_RHIGH   = 4'd8,
        PH_HOLD    = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        MODE_CMD      = 2'd0,
        MODE_CMD_DATA = 2'd1,
        MODE_READ     = 2'd2,
        MODE_DATA     = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WLOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RSAMPLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RHIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_READ = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DATA = 3'd6;

    localparam logic [3:0] LAST_READ_BIT  = 4'(READ_BITS - 1);
    localparam logic [3:0] LAST_WRITE_BIT = 4'd7;
    localparam logic [3:0] KEPT_BITS      = 4'(TEMP_W);

    // timing registers
    logic [CFG_W-1:0] r_settle, r_wlow, r_whigh, r_rsample, r_rhigh, r_hold_read, r_hold_data;

    // sequencer state
    t_phase            r_phase, n_phase;
    t_mode             r_mode, n_mode;
    logic [CFG_W-1:0]  r_tc, n_tc;
    logic [3:0]        r_bit, n_bit;
    logic [7:0]        r_out_shift, n_out_shift;
    logic [7:0]        r_pending, n_pending;
    logic [TEMP_W-1:0] r_read_shift, n_read_shift;
    logic [TEMP_W-1:0] r_reading, n_reading;
    logic [2:0]        r_device, n_device;
    logic [CFG_W-1:0]  r_hold_len, n_hold_len;

    // output buffer
    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;
    t_out_item n_res;

    logic             acc, taken;
    logic             done;
    logic [CFG_W-1:0] len, need, tc_inc;
    logic             fire;
    t_in_item         it;

    assign it     = i_item.payload;
    assign acc    = i_item.valid && i_item.ready;
    assign taken  = o_res.valid && o_res.ready;

    assign i_item.ready = !r_skid_valid;
    assign o_res.valid  = r_out_valid;
    assign o_res.payload = r_out;

    // duration of the timed step in the current phase
    always_comb begin
        case (r_phase)
            PH_SETTLE, PH_TAIL:  len = r_settle;
            PH_WLOW:             len = r_wlow;
            PH_WHIGH:            len = r_whigh;
            PH_RELEASE, PH_RHIGH: len = r_rhigh;
            PH_RLOW, PH_RWAIT:   len = r_rsample;
            PH_HOLD:             len = r_hold_len;
            default:             len = '0;
        endcase
    end

    // a zero-length step still takes one tick
    assign need   = (len == '0) ? CFG_W'(1) : len;
    assign tc_inc = r_tc + CFG_W'(1);
    assign fire   = (tc_inc >= need);

    always_comb begin
        n_phase      = r_phase;
        n_mode       = r_mode;
        n_tc         = r_tc;
        n_bit        = r_bit;
        n_out_shift  = r_out_shift;
        n_pending    = r_pending;
        n_read_shift = r_read_shift;
        n_reading    = r_reading;
        n_device     = r_device;
        n_hold_len   = r_hold_len;
        done         = 1'b0;

        if (it.action) begin
            if (r_phase == PH_IDLE) begin
                n_device    = it.device_id;
                n_out_shift = it.command_byte;
                n_pending   = it.data_byte;
                if (it.send_data) begin
                    n_mode = MODE_CMD_DATA;
                end else if (it.read_result) begin
                    n_mode = MODE_READ;
                end else begin
                    n_mode = MODE_CMD;
                end
                n_bit   = '0;
                n_phase = PH_SETTLE;
                n_tc    = '0;
            end
        end else if (r_phase == PH_IDLE) begin
            n_tc = '0;
        end else begin
            n_tc = fire ? '0 : tc_inc;
            if (fire) begin
                case (r_phase)
                    PH_SETTLE: begin
                        n_bit   = '0;
                        n_phase = PH_WLOW;
                    end
                    PH_WLOW: n_phase = PH_WHIGH;
                    PH_WHIGH: begin
                        if (r_bit < LAST_WRITE_BIT) begin
                            n_bit   = r_bit + 4'd1;
                            n_phase = PH_WLOW;
                        end else begin
                            case (r_mode)
                                MODE_CMD_DATA: begin
                                    n_out_shift = r_pending;
                                    n_mode      = MODE_DATA;
                                    n_bit       = '0;
                                    n_phase     = PH_WLOW;
                                end
                                MODE_READ: begin
                                    n_bit        = '0;
                                    n_read_shift = '0;
                                    n_phase      = PH_RELEASE;
                                end
                                MODE_DATA: begin
                                    if (r_hold_data == '0) begin
                                        n_phase = PH_IDLE;
                                        done    = 1'b1;
                                    end else begin
                                        n_hold_len = r_hold_data;
                                        n_phase    = PH_HOLD;
                                    end
                                end
                                default: n_phase = PH_TAIL;
                            endcase
                        end
                    end
                    PH_TAIL: begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    PH_RELEASE: n_phase = PH_RLOW;
                    PH_RLOW: begin
                        if (r_bit < KEPT_BITS && it.dq_in) begin
                            n_read_shift[r_bit] = 1'b1;
                        end
                        n_phase = PH_RWAIT;
                    end
                    PH_RWAIT: n_phase = PH_RHIGH;
                    PH_RHIGH: begin
                        if (r_bit >= LAST_READ_BIT) begin
                            n_reading = r_read_shift;
                            if (r_hold_read == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_hold_len = r_hold_read;
                                n_phase    = PH_HOLD;
                            end
                        end else begin
                            n_bit   = r_bit + 4'd1;
                            n_phase = PH_RLOW;
                        end
                    end
                    PH_HOLD: begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // line levels follow the phase after the step
    always_comb begin
        n_res             = '0;
        n_res.busy_res    = (n_phase != PH_IDLE);
        n_res.done_res    = done;
        n_res.temperature = n_reading;
        case (n_phase)
            PH_SETTLE: begin
                n_res.dq_drive   = 1'b1;
                n_res.select_out = n_device;
            end
            PH_WLOW, PH_WHIGH: begin
                n_res.clock_out  = (n_phase == PH_WHIGH);
                n_res.dq_drive   = 1'b1;
                n_res.dq_out     = n_out_shift[n_bit[2:0]];
                n_res.select_out = n_device;
            end
            PH_TAIL: begin
                n_res.clock_out  = 1'b1;
                n_res.dq_drive   = 1'b1;
                n_res.dq_out     = n_out_shift[7];
                n_res.select_out = n_device;
            end
            PH_RELEASE, PH_RHIGH: begin
                n_res.clock_out  = 1'b1;
                n_res.select_out = n_device;
            end
            PH_RLOW, PH_RWAIT: n_res.select_out = n_device;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= CFG_W'(10);
            r_wlow      <= CFG_W'(10);
            r_whigh     <= CFG_W'(30);
            r_rsample   <= CFG_W'(5);
            r_rhigh     <= CFG_W'(10);
            r_hold_read <= CFG_W'(1000);
            r_hold_data <= CFG_W'(30000);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SETTLE:    r_settle    <= i_cfg_data;
                REG_WLOW:      r_wlow      <= i_cfg_data;
                REG_WHIGH:     r_whigh     <= i_cfg_data;
                REG_RSAMPLE:   r_rsample   <= i_cfg_data;
                REG_RHIGH:     r_rhigh     <= i_cfg_data;
                REG_HOLD_READ: r_hold_read <= i_cfg_data;
                REG_HOLD_DATA: r_hold_data <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_mode       <= MODE_CMD;
            r_tc         <= '0;
            r_bit        <= '0;
            r_out_shift  <= '0;
            r_pending    <= '0;
            r_read_shift <= '0;
            r_reading    <= '0;
            r_device     <= '0;
            r_hold_len   <= '0;
        end else if (acc) begin
            r_phase      <= n_phase;
            r_mode       <= n_mode;
            r_tc         <= n_tc;
            r_bit        <= n_bit;
            r_out_shift  <= n_out_shift;
            r_pending    <= n_pending;
            r_read_shift <= n_read_shift;
            r_reading    <= n_reading;
            r_device     <= n_device;
            r_hold_len   <= n_hold_len;
        end
    end

    // result register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || taken) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= acc;
                    r_skid       <= n_res;
                end else begin
                    r_out_valid <= acc;
                    r_out       <= n_res;
                end
            end else if (acc) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    `TWTM_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `TWTM_ASSERT_NEXT(a_start_from_idle, i_clk, i_rst_n,
        acc && it.action && r_phase == PH_IDLE, r_phase == PH_SETTLE)
    `TWTM_ASSERT_SAME(a_hold_nonzero, i_clk, i_rst_n, r_phase == PH_HOLD, r_hold_len != '0)

endmodule
